// ----- sv/ssd_pkg.sv -----
// shared types and constants for the seven-segment display command formatter
// no dependencies
`default_nettype none

package ssd_pkg;

	localparam logic [2:0] OP_BRIGHT    = 3'd0;
	localparam logic [2:0] OP_DIGIT     = 3'd1;
	localparam logic [2:0] OP_DIGIT_PT  = 3'd2;
	localparam logic [2:0] OP_RAW       = 3'd3;
	localparam logic [2:0] OP_NUMBER    = 3'd4;
	localparam logic [2:0] OP_CLEAR     = 3'd5;

	localparam logic [1:0] KIND_PAIR    = 2'd0;
	localparam logic [1:0] KIND_NUMBER  = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	localparam logic [7:0] BRIGHT_CMD   = 8'h48;
	localparam logic [7:0] ADDR_BASE    = 8'h68;
	localparam logic [7:0] POINT_BIT    = 8'h80;
	localparam logic [7:0] CODE_POINT   = 8'd11;
	localparam logic [13:0] NUM_MAX     = 14'd9999;
	localparam logic [12:0] RECIP_TEN   = 13'd6554;
	localparam int          RECIP_SHIFT = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  first;
		logic [7:0]  second;
		logic [13:0] num;
	} job_t;

	function automatic logic [7:0] seg_pattern(input logic [7:0] code);
		logic [7:0] p;
		case (code)
			8'd0: p = 8'h3f;
			8'd1: p = 8'h06;
			8'd2: p = 8'h5b;
			8'd3: p = 8'h4f;
			8'd4: p = 8'h66;
			8'd5: p = 8'h6d;
			8'd6: p = 8'h7d;
			8'd7: p = 8'h07;
			8'd8: p = 8'h7f;
			8'd9: p = 8'h6f;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

	function automatic logic [7:0] digit_addr(input logic [1:0] pos);
		return ADDR_BASE + {5'd0, pos, 1'b0};
	endfunction

endpackage

`default_nettype wire

// ----- sv/ssd_cmd_if.sv -----
// command channel: valid/ready handshake carrying one display command
// no dependencies
`default_nettype none

interface ssd_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [1:0]  digit_pos;
	logic [7:0]  value;
	logic        point_on;
	logic [13:0] number;

	modport source (output valid, opcode, digit_pos, value, point_on, number, input ready);
	modport sink (input valid, opcode, digit_pos, value, point_on, number, output ready);
endinterface

`default_nettype wire

// ----- sv/ssd_byte_if.sv -----
// bus byte channel: valid/ready handshake carrying one framed bus byte
// no dependencies
`default_nettype none

interface ssd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       frame_start;
	logic       frame_stop;
	logic       last;

	modport source (output valid, bus_byte, frame_start, frame_stop, last, input ready);
	modport sink (input valid, bus_byte, frame_start, frame_stop, last, output ready);
endinterface

`default_nettype wire

// ----- sv/ssd_front.sv -----
// front end: accepts command words, classifies them into byte jobs
// depends on ssd_pkg and ssd_cmd_if
`default_nettype none

module ssd_front import ssd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ssd_cmd_if.sink   cmd,
	output job_t      job,
	output logic      job_valid,
	input  wire logic job_ready
);

	job_t job_s1;
	logic vld_s1;
	job_t cls;
	logic cls_ok;
	logic take;
	logic [7:0] dig_addr;
	logic [7:0] pt_seg;

	assign cmd.ready = !vld_s1 || job_ready;
	assign take = cmd.valid && cmd.ready;
	assign dig_addr = digit_addr(cmd.digit_pos);

	always_comb begin
		if (cmd.value == CODE_POINT) begin
			pt_seg = POINT_BIT;
		end else if (cmd.value < 8'd10) begin
			pt_seg = seg_pattern(cmd.value) | (cmd.point_on ? POINT_BIT : 8'h00);
		end else begin
			pt_seg = 8'h00;
		end
	end

	always_comb begin
		cls.kind = KIND_PAIR;
		cls.first = dig_addr;
		cls.second = 8'h00;
		cls.num = (cmd.number > NUM_MAX) ? NUM_MAX : cmd.number;
		cls_ok = 1'b1;
		case (cmd.opcode)
			OP_BRIGHT: begin
				cls.first = BRIGHT_CMD;
				cls.second = cmd.value;
			end
			OP_DIGIT: cls.second = seg_pattern(cmd.value);
			OP_DIGIT_PT: cls.second = pt_seg;
			OP_RAW: cls.second = cmd.value;
			OP_NUMBER: cls.kind = KIND_NUMBER;
			OP_CLEAR: cls.kind = KIND_CLEAR;
			default: cls_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= take && cls_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_s1 <= cls;
		end
	end

	assign job = job_s1;
	assign job_valid = vld_s1;

endmodule

`default_nettype wire

// ----- sv/ssd_queue.sv -----
// short job queue between the front end and the byte sequencer
// depends on ssd_pkg
`default_nettype none

module ssd_queue import ssd_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      in_job,
	input  wire logic in_valid,
	output logic      in_ready,
	output job_t      out_job,
	output logic      out_valid,
	input  wire logic out_ready
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic push;
	logic pop;

	assign in_ready = cnt_q != FULL_CNT;
	assign out_valid = cnt_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_job = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_IDX) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_IDX) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_job;
		end
	end

endmodule

`default_nettype wire

// ----- sv/ssd_back.sv -----
// back end: walks one job at a time and emits its framed bus bytes
// depends on ssd_pkg and ssd_byte_if
`default_nettype none

module ssd_back import ssd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      job,
	input  wire logic job_valid,
	output logic      job_ready,
	ssd_byte_if.source bus
);

	logic [1:0]  kind_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic [13:0] num_q;
	logic [1:0]  fi_q;
	logic        half_q;
	logic        busy_q;

	logic        out_vld_q;
	logic [7:0]  out_byte_q;
	logic        out_start_q;
	logic        out_stop_q;
	logic        out_last_q;

	logic        adv;
	logic        emit;
	logic        is_last;
	logic        load;
	logic [7:0]  addr;
	logic [26:0] prod;
	logic [10:0] quo;
	logic [7:0]  quo_ten;
	logic [3:0]  rem;

	assign adv = !out_vld_q || bus.ready;
	assign emit = busy_q && adv;
	assign is_last = half_q && (kind_q == KIND_PAIR || fi_q == 2'd3);
	assign load = (!busy_q || (emit && is_last)) && job_valid;
	assign job_ready = load;

	// divide by ten through a reciprocal, exact below 10000
	assign prod = num_q * RECIP_TEN;
	assign quo = prod[26:RECIP_SHIFT];
	assign quo_ten = quo[3:0] * 4'd10;
	assign rem = num_q[3:0] - quo_ten[3:0];

	always_comb begin
		case (kind_q)
			KIND_NUMBER: addr = digit_addr(~fi_q);
			KIND_CLEAR: addr = digit_addr(fi_q);
			default: addr = first_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			out_vld_q <= 1'b0;
			fi_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= busy_q;
			end
			if (load) begin
				busy_q <= 1'b1;
				fi_q <= '0;
				half_q <= 1'b0;
			end else if (emit) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				half_q <= !half_q;
				if (half_q) begin
					fi_q <= fi_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= job.kind;
			first_q <= job.first;
			second_q <= job.second;
			num_q <= job.num;
		end else if (emit && !half_q && kind_q == KIND_NUMBER) begin
			second_q <= seg_pattern({4'd0, rem});
			num_q <= {3'd0, quo};
		end
		if (emit) begin
			out_byte_q <= half_q ? second_q : addr;
			out_start_q <= !half_q;
			out_stop_q <= half_q;
			out_last_q <= is_last;
		end
	end

	assign bus.valid = out_vld_q;
	assign bus.bus_byte = out_byte_q;
	assign bus.frame_start = out_start_q;
	assign bus.frame_stop = out_stop_q;
	assign bus.last = out_last_q;

endmodule

`default_nettype wire

// ----- sv/seven_segment_display_command_formatter_core.sv -----
// seven-segment display command formatter: command words in, framed bus bytes out
// depends on ssd_pkg, ssd_cmd_if, ssd_byte_if, ssd_front, ssd_queue, ssd_back
//
// cmd carries one display command per word; bus carries one bus byte per word,
// each tagged with frame_start, frame_stop and last (final byte of a command).
// brightness, digit, point and raw commands give one frame of two bytes;
// show-number and clear give four frames, eight bytes. opcodes 6 and 7 give none.
// a command accepted by the front register passes through the job queue into the
// sequencer and then the output register before its first byte shows. the front
// end takes a command every cycle while the job queue has room; the byte
// sequencer sends one byte per cycle while bus.ready is high, so the sustained
// command rate is set by the bytes each command gives and by the one-byte-per-cycle
// output register. each digit of show-number comes from a divide-by-ten step done
// once per frame in the sequencer. reset empties the front register, queue and
// output register; no clearing pass is needed. when bus.ready is low the output
// word holds, the sequencer waits, and the queue and front end fill before
// cmd.ready drops.
`default_nettype none

module seven_segment_display_command_formatter_core import ssd_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssd_cmd_if.sink    cmd,
	ssd_byte_if.source bus
);

	job_t f_job;
	logic f_valid;
	logic f_ready;
	job_t b_job;
	logic b_valid;
	logic b_ready;

	ssd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.job       (f_job),
		.job_valid (f_valid),
		.job_ready (f_ready)
	);

	ssd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_job    (f_job),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.out_job   (b_job),
		.out_valid (b_valid),
		.out_ready (b_ready)
	);

	ssd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (b_job),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.bus       (bus)
	);

endmodule

`default_nettype wire
